/* rtl/ricm_pkg.sv */
// ----------------------------------------------------------------------------
// ricm_pkg
// Shared widths, codes, command/status types and code helpers for the
// rotation invariant code matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package ricm_pkg;

   localparam int CODE_W          = 64;
   localparam int SIDE_W          = 4;
   localparam int COUNT_CSR_W     = 9;
   localparam int DIST_W          = 7;
   localparam int SLOT_W          = 8;
   localparam int TURN_W          = 2;
   localparam int TURNS           = 4;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 9;
   localparam int MIN_SIDE        = 3;
   localparam int MAX_SIDE        = 8;
   localparam int MAX_ENTRIES_DEF = 256;

   localparam logic [SIDE_W-1:0]      SIDE_RESET  = SIDE_W'(5);
   localparam logic [CSR_INDEX_W-1:0] CSR_CODE_SIDE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ENTRY_COUNT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CORR_LIMIT  = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic load;
      logic write_en;
      logic issue;
      logic publish;
   } ctrl_cmd_type;

   typedef struct packed {
      logic more;
      logic pipe_empty;
      logic out_free;
   } ctrl_status_type;

   function automatic logic [SIDE_W-1:0] eff_side(input logic [SIDE_W-1:0] side);
      logic [SIDE_W-1:0] s;
      s = side;
      if (s < SIDE_W'(MIN_SIDE)) s = SIDE_W'(MIN_SIDE);
      if (s > SIDE_W'(MAX_SIDE)) s = SIDE_W'(MAX_SIDE);
      return s;
   endfunction

   function automatic logic [DIST_W-1:0] cell_count(input logic [SIDE_W-1:0] side);
      logic [DIST_W-1:0] s7;
      s7 = DIST_W'(side);
      return DIST_W'(s7 * s7);
   endfunction

   function automatic logic [CODE_W-1:0] cell_mask(input logic [DIST_W-1:0] cells);
      logic [CODE_W-1:0] m;
      for (int i = 0; i < CODE_W; i++) begin
         m[i] = (i < int'(cells));
      end
      return m;
   endfunction

   function automatic logic [CODE_W-1:0] turn_code(input logic [CODE_W-1:0] code,
                                                   input logic [SIDE_W-1:0] side,
                                                   input logic [TURN_W-1:0] turn);
      logic [CODE_W-1:0] res;
      int ny;
      int nx;
      res = '0;
      for (int sv = MIN_SIDE; sv <= MAX_SIDE; sv++) begin
         if (side == SIDE_W'(sv)) begin
            for (int y = 0; y < sv; y++) begin
               for (int x = 0; x < sv; x++) begin
                  case (turn)
                     2'd1: begin
                        ny = x;
                        nx = sv - 1 - y;
                     end
                     2'd2: begin
                        ny = sv - 1 - y;
                        nx = sv - 1 - x;
                     end
                     2'd3: begin
                        ny = sv - 1 - x;
                        nx = y;
                     end
                     default: begin
                        ny = y;
                        nx = x;
                     end
                  endcase
                  res[ny * sv + nx] = code[y * sv + x];
               end
            end
         end
      end
      return res;
   endfunction

   function automatic logic [3:0] pop8(input logic [7:0] v);
      logic [3:0] c;
      c = '0;
      for (int i = 0; i < 8; i++) begin
         c = c + 4'(v[i]);
      end
      return c;
   endfunction

   function automatic logic [DIST_W-1:0] pop64(input logic [CODE_W-1:0] v);
      logic [DIST_W-1:0] c;
      c = '0;
      for (int b = 0; b < 8; b++) begin
         c = c + DIST_W'(pop8(v[b*8 +: 8]));
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/rotation_invariant_code_match.sv */
// ----------------------------------------------------------------------------
// rotation_invariant_code_match
// Matches a square binary marker code, in all four quarter turns, against a
// stored dictionary: exact match first, else nearest by Hamming distance.
// ----------------------------------------------------------------------------
//   channel  dir  handshake          payload
//   req      in   req_valid/stall    cmd, entry_slot, code_bits
//   rsp      out  rsp_valid/stall    found, exact_hit, match_index,
//                                    turn_count, best_distance
//   csr      in   csr_valid/ready    csr_index, csr_data
//
// A write word is taken only while idle. With n the entry_count capped at
// MAX_ENTRIES, a query scans n entries, drains the compare pipeline and
// publishes its result word; req_stall is high until that publish. The
// dictionary memory has one read port and is scanned one entry per cycle,
// all four turns compared in parallel, then a three-stage compare pipeline
// drains. Reset is synchronous; the dictionary is not cleared. A result
// waits in the output register while rsp_stall is high, and the next query
// holds in its emit state until that register frees; write words are
// stalled meanwhile too.
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_invariant_code_match #(
   parameter int MAX_ENTRIES = ricm_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic                              req_cmd,
   input  wire logic [ricm_pkg::SLOT_W-1:0]       req_entry_slot,
   input  wire logic [ricm_pkg::CODE_W-1:0]       req_code_bits,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_found,
   output logic                                   rsp_exact_hit,
   output logic [ricm_pkg::SLOT_W-1:0]            rsp_match_index,
   output logic [ricm_pkg::TURN_W-1:0]            rsp_turn_count,
   output logic [ricm_pkg::DIST_W-1:0]            rsp_best_distance,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ricm_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [ricm_pkg::CSR_DATA_W-1:0]   csr_data
);
   import ricm_pkg::*;

   logic [SIDE_W-1:0]      code_side_ff, code_side_in;
   logic [COUNT_CSR_W-1:0] entry_count_ff, entry_count_in;
   logic [DIST_W-1:0]      corr_limit_ff, corr_limit_in;
   logic [SIDE_W-1:0]      side_eff;
   ctrl_cmd_type           cmd;
   ctrl_status_type        status;

   assign csr_ready = 1'b1;

   always_comb begin
      code_side_in   = code_side_ff;
      entry_count_in = entry_count_ff;
      corr_limit_in  = corr_limit_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_CODE_SIDE:   code_side_in   = csr_data[SIDE_W-1:0];
            CSR_ENTRY_COUNT: entry_count_in = csr_data[COUNT_CSR_W-1:0];
            CSR_CORR_LIMIT:  corr_limit_in  = csr_data[DIST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_side_ff   <= SIDE_RESET;
         entry_count_ff <= '0;
         corr_limit_ff  <= '0;
      end else begin
         code_side_ff   <= code_side_in;
         entry_count_ff <= entry_count_in;
         corr_limit_ff  <= corr_limit_in;
      end
   end

   assign side_eff = eff_side(code_side_ff);

   ricm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   ricm_datapath #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .wr_slot           (req_entry_slot),
      .code_bits         (req_code_bits),
      .side              (side_eff),
      .entry_count       (entry_count_ff),
      .correction_limit  (corr_limit_ff),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_found         (rsp_found),
      .rsp_exact_hit     (rsp_exact_hit),
      .rsp_match_index   (rsp_match_index),
      .rsp_turn_count    (rsp_turn_count),
      .rsp_best_distance (rsp_best_distance)
   );

endmodule

`default_nettype wire

/* rtl/ricm_ctrl.sv */
// ----------------------------------------------------------------------------
// ricm_ctrl
// Sequencer: takes words, starts a dictionary scan per query, drains the
// compare pipeline and hands the result to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ricm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_cmd,
   output logic                        req_stall,
   input  wire ricm_pkg::ctrl_status_type status,
   output ricm_pkg::ctrl_cmd_type      cmd
);
   import ricm_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;
   localparam logic [1:0] ST_EMIT  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       accept;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_cmd == CMD_WRITE) begin
               cmd.write_en = 1'b1;
            end
            if (accept && req_cmd == CMD_QUERY) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.issue = status.more;
            if (!status.more) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.pipe_empty) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               cmd.publish = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

/* rtl/ricm_datapath.sv */
// ----------------------------------------------------------------------------
// ricm_datapath
// Dictionary memory, rotation registers, four-way distance pipeline, best
// candidate tracking and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ricm_datapath #(
   parameter int MAX_ENTRIES = ricm_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire ricm_pkg::ctrl_cmd_type            cmd,
   output ricm_pkg::ctrl_status_type              status,
   input  wire logic [ricm_pkg::SLOT_W-1:0]       wr_slot,
   input  wire logic [ricm_pkg::CODE_W-1:0]       code_bits,
   input  wire logic [ricm_pkg::SIDE_W-1:0]       side,
   input  wire logic [ricm_pkg::COUNT_CSR_W-1:0]  entry_count,
   input  wire logic [ricm_pkg::DIST_W-1:0]       correction_limit,
   input  wire logic                              rsp_stall,
   output logic                                   rsp_valid,
   output logic                                   rsp_found,
   output logic                                   rsp_exact_hit,
   output logic [ricm_pkg::SLOT_W-1:0]            rsp_match_index,
   output logic [ricm_pkg::TURN_W-1:0]            rsp_turn_count,
   output logic [ricm_pkg::DIST_W-1:0]            rsp_best_distance
);
   import ricm_pkg::*;

   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic [CODE_W-1:0] mem [MAX_ENTRIES];

   logic [CODE_W-1:0] rot_ff [TURNS];
   logic [CODE_W-1:0] rot_in [TURNS];
   logic [CODE_W-1:0] mask_ff, mask_in;
   logic [DIST_W-1:0] cells_now;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic [31:0]       slot32, count32;
   logic              slot_ok;

   logic [CODE_W-1:0] rd_data_ff;
   logic              v1_ff, v2_ff, v3_ff;
   logic [IDX_W-1:0]  e1_ff, e2_ff, e3_ff;
   logic [DIST_W-1:0] d2_ff [TURNS];
   logic [DIST_W-1:0] d2_in [TURNS];
   logic [DIST_W-1:0] lmin_d3_ff, lmin_d3_in;
   logic [TURN_W-1:0] lmin_r3_ff, lmin_r3_in;
   logic [TURNS-1:0]  z3_ff, z3_in;

   logic [DIST_W-1:0] best_d_ff, best_d_in;
   logic [IDX_W-1:0]  best_e_ff, best_e_in;
   logic [TURN_W-1:0] best_r_ff, best_r_in;
   logic [TURNS-1:0]  hit_ff, hit_in;
   logic [IDX_W-1:0]  hit_e_ff [TURNS];
   logic [IDX_W-1:0]  hit_e_in [TURNS];

   logic              rsp_valid_ff, rsp_valid_in;
   logic              found_ff, exact_ff;
   logic [SLOT_W-1:0] index_ff;
   logic [TURN_W-1:0] turn_ff;
   logic [DIST_W-1:0] dist_ff;
   logic              res_exact, res_found;
   logic [IDX_W-1:0]  res_e;
   logic [TURN_W-1:0] res_r;
   logic [31:0]       res_e32;

   // load setup
   always_comb begin
      cells_now = cell_count(side);
      mask_in   = cell_mask(cells_now);
      for (int r = 0; r < TURNS; r++) begin
         rot_in[r] = turn_code(code_bits & mask_in, side, TURN_W'(r));
      end
      count32  = 32'(entry_count);
      count_in = (count32 > 32'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : count32[CNT_W-1:0];
      slot32   = 32'(wr_slot);
      slot_ok  = slot32 < 32'(MAX_ENTRIES);
   end

   always_comb begin
      addr_in = addr_ff;
      if (cmd.load)       addr_in = '0;
      else if (cmd.issue) addr_in = addr_ff + CNT_W'(1);
   end

   // memory write and registered read
   always_ff @(posedge clock) begin
      if (cmd.write_en && slot_ok) begin
         mem[slot32[IDX_W-1:0]] <= code_bits;
      end
      if (cmd.issue) begin
         rd_data_ff <= mem[addr_ff[IDX_W-1:0]];
      end
   end

   // distance stage and local minimum over the four turns
   always_comb begin
      for (int r = 0; r < TURNS; r++) begin
         d2_in[r] = pop64((rd_data_ff & mask_ff) ^ rot_ff[r]);
      end
      lmin_d3_in = d2_ff[0];
      lmin_r3_in = '0;
      for (int r = 1; r < TURNS; r++) begin
         if (d2_ff[r] < lmin_d3_in) begin
            lmin_d3_in = d2_ff[r];
            lmin_r3_in = TURN_W'(r);
         end
      end
      for (int r = 0; r < TURNS; r++) begin
         z3_in[r] = (d2_ff[r] == '0);
      end
   end

   // best candidate and first exact hit per turn
   always_comb begin
      best_d_in = best_d_ff;
      best_e_in = best_e_ff;
      best_r_in = best_r_ff;
      hit_in    = hit_ff;
      for (int r = 0; r < TURNS; r++) begin
         hit_e_in[r] = hit_e_ff[r];
      end
      if (cmd.load) begin
         best_d_in = cells_now;
         best_e_in = '0;
         best_r_in = '0;
         hit_in    = '0;
      end else if (v3_ff) begin
         if (lmin_d3_ff < best_d_ff) begin
            best_d_in = lmin_d3_ff;
            best_e_in = e3_ff;
            best_r_in = lmin_r3_ff;
         end
         for (int r = 0; r < TURNS; r++) begin
            if (z3_ff[r] && !hit_ff[r]) begin
               hit_in[r]   = 1'b1;
               hit_e_in[r] = e3_ff;
            end
         end
      end
   end

   // result select: lowest turn with an exact hit wins
   always_comb begin
      res_exact = |hit_ff;
      res_r     = best_r_ff;
      res_e     = best_e_ff;
      for (int r = TURNS - 1; r >= 0; r--) begin
         if (hit_ff[r]) begin
            res_r = TURN_W'(r);
            res_e = hit_e_ff[r];
         end
      end
      res_found = res_exact || ((count_ff != '0) && (best_d_ff <= correction_limit));
      res_e32   = 32'(res_e);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.publish)              rsp_valid_in = 1'b1;
      else if (!rsp_stall)          rsp_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
         addr_ff      <= '0;
         count_ff     <= '0;
      end else begin
         v1_ff        <= cmd.issue;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         rsp_valid_ff <= rsp_valid_in;
         addr_ff      <= addr_in;
         if (cmd.load) count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mask_ff <= mask_in;
         for (int r = 0; r < TURNS; r++) begin
            rot_ff[r] <= rot_in[r];
         end
      end
      e1_ff <= addr_ff[IDX_W-1:0];
      e2_ff <= e1_ff;
      e3_ff <= e2_ff;
      for (int r = 0; r < TURNS; r++) begin
         d2_ff[r]    <= d2_in[r];
         hit_e_ff[r] <= hit_e_in[r];
      end
      lmin_d3_ff <= lmin_d3_in;
      lmin_r3_ff <= lmin_r3_in;
      z3_ff      <= z3_in;
      best_d_ff  <= best_d_in;
      best_e_ff  <= best_e_in;
      best_r_ff  <= best_r_in;
      hit_ff     <= hit_in;
      if (cmd.publish) begin
         found_ff <= res_found;
         exact_ff <= res_exact;
         index_ff <= res_e32[SLOT_W-1:0];
         turn_ff  <= res_r;
         dist_ff  <= res_exact ? '0 : best_d_ff;
      end
   end

   assign status.more       = addr_ff < count_ff;
   assign status.pipe_empty = !v1_ff && !v2_ff && !v3_ff;
   assign status.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = found_ff;
   assign rsp_exact_hit     = exact_ff;
   assign rsp_match_index   = index_ff;
   assign rsp_turn_count    = turn_ff;
   assign rsp_best_distance = dist_ff;

endmodule

`default_nettype wire

/* rtl/ricm_checker.sv */
// ----------------------------------------------------------------------------
// ricm_checker
// Port-level checks for the rotation invariant code matcher.
// ----------------------------------------------------------------------------
`default_nettype none

module ricm_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_stall,
   input wire logic                         req_cmd,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_stall,
   input wire logic                         rsp_found,
   input wire logic                         rsp_exact_hit,
   input wire logic [ricm_pkg::SLOT_W-1:0]  rsp_match_index,
   input wire logic [ricm_pkg::TURN_W-1:0]  rsp_turn_count,
   input wire logic [ricm_pkg::DIST_W-1:0]  rsp_best_distance
);
   import ricm_pkg::*;

   a_exact_is_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exact_hit |-> rsp_found)
      else $error("exact hit without found");

   a_exact_zero_dist: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exact_hit |-> rsp_best_distance == '0)
      else $error("exact hit with nonzero distance");

   a_corrected_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found && !rsp_exact_hit |-> rsp_best_distance != '0)
      else $error("corrected match with zero distance");

   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_cmd == CMD_QUERY |=> req_stall)
      else $error("query word not followed by busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_found)
         && $stable(rsp_exact_hit) && $stable(rsp_match_index)
         && $stable(rsp_turn_count) && $stable(rsp_best_distance))
      else $error("stalled result word changed");

endmodule

bind rotation_invariant_code_match ricm_checker u_ricm_checker (.*);

`default_nettype wire
